[rtl/indexed_array_store_engine_defines.svh]
// Assertion macros shared by the checker of the indexed array store engine.
`ifndef INDEXED_ARRAY_STORE_ENGINE_DEFINES_SVH
`define INDEXED_ARRAY_STORE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IASE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iase check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IASE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iase check failed");

`endif

[rtl/iase_pkg.sv]
// Package of the indexed array store engine: sizes, codes and sequencer states.
package iase_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = ADDR_BITS + 1;

    typedef enum logic [2:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_MAX    = 3'd4,
        CMD_MIN    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_GET,
        ST_SHIFT,
        ST_PLACE,
        ST_SCAN,
        ST_FIN
    } state_t;

endpackage

[rtl/indexed_array_store_engine.sv]
// Indexed array store engine: bounded store of signed words with a live length.
// Steps: get reads the indexed entry, search/max/min scan the live entries, and insert
//   moves the entries from the index up one place unless it appends or is refused.
// One transaction at a time; the scan/shift steps through the entry memory, whose single
//   read port gives one read per cycle.
// Reset: length and per-entry valid bits clear at once; no clearing pass.
module indexed_array_store_engine
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: loads the length counter
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [6:0]  index,
    input  logic signed [31:0] value,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] read_value,
    output logic [5:0]  found_index,
    output logic        found,
    output logic [1:0]  status,
    output logic [6:0]  live_length
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    iase_pkg::state_t state_reg, state_next;

    iase_pkg::cmd_t cmd_reg, cmd_next;
    logic [iase_pkg::CNT_BITS-1:0]  idx_reg, idx_next;
    logic signed [iase_pkg::WORD_BITS-1:0] val_reg, val_next;
    logic [iase_pkg::CNT_BITS-1:0]  count_reg, count_next;

    // address of the memory word arriving in rd_data_reg
    logic [iase_pkg::ADDR_BITS-1:0] ptr_reg, ptr_next;
    // running max/min
    logic signed [iase_pkg::WORD_BITS-1:0] best_reg, best_next;

    // result held between the sequencer and the output register
    logic signed [iase_pkg::WORD_BITS-1:0] res_val_reg, res_val_next;
    logic [iase_pkg::ADDR_BITS-1:0] res_fidx_reg, res_fidx_next;
    logic                           res_found_reg, res_found_next;
    iase_pkg::status_t              res_status_reg, res_status_next;

    // output register
    logic                           out_valid_reg;
    logic signed [iase_pkg::WORD_BITS-1:0] out_val_reg;
    logic [iase_pkg::ADDR_BITS-1:0] out_fidx_reg;
    logic                           out_found_reg;
    iase_pkg::status_t              out_status_reg;
    logic [iase_pkg::CNT_BITS-1:0]  out_len_reg;

    // entry memory with one write and one registered read port
    logic signed [iase_pkg::WORD_BITS-1:0] mem [iase_pkg::DEPTH];
    logic [iase_pkg::DEPTH-1:0]     vld_reg;
    logic signed [iase_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                           rd_vld_reg;

    logic                           mem_we;
    logic [iase_pkg::ADDR_BITS-1:0] mem_waddr;
    logic signed [iase_pkg::WORD_BITS-1:0] mem_wdata;
    logic [iase_pkg::ADDR_BITS-1:0] mem_raddr;

    // ------------------------------------------------------------------
    // Shared decode and compare
    // ------------------------------------------------------------------
    logic signed [iase_pkg::WORD_BITS-1:0] eff_rd;
    logic get_oor, ins_oor, is_full, is_empty, ins_append;
    logic scan_last, shift_last, key_hit, better;
    logic out_free, accept;

    // never-written entries read as zero
    assign eff_rd = rd_vld_reg ? rd_data_reg : '0;

    assign get_oor    = (idx_reg >= count_reg);
    assign ins_oor    = (idx_reg > count_reg);
    assign is_full    = (count_reg == iase_pkg::CNT_BITS'(iase_pkg::DEPTH));
    assign is_empty   = (count_reg == '0);
    assign ins_append = (idx_reg == count_reg);
    assign scan_last  = (({1'b0, ptr_reg} + 1'b1) == count_reg);
    assign shift_last = ({1'b0, ptr_reg} == idx_reg);
    assign key_hit    = (eff_rd == val_reg);
    // single magnitude comparator, direction picked by the command
    assign better     = (cmd_reg == iase_pkg::CMD_MAX) ? (eff_rd > best_reg)
                                                       : (eff_rd < best_reg);

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != iase_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iase_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = iase_pkg::ST_START;
            end
            iase_pkg::ST_START:
            begin
                unique case (cmd_reg)
                    iase_pkg::CMD_GET:
                        state_next = get_oor ? iase_pkg::ST_FIN : iase_pkg::ST_GET;
                    iase_pkg::CMD_INSERT:
                        state_next = (ins_oor || is_full || ins_append) ?
                                     iase_pkg::ST_FIN : iase_pkg::ST_SHIFT;
                    iase_pkg::CMD_SEARCH, iase_pkg::CMD_MAX, iase_pkg::CMD_MIN:
                        state_next = is_empty ? iase_pkg::ST_FIN : iase_pkg::ST_SCAN;
                    default:
                        state_next = iase_pkg::ST_FIN;
                endcase
            end
            iase_pkg::ST_GET:
                state_next = iase_pkg::ST_FIN;
            iase_pkg::ST_SHIFT:
            begin
                if (shift_last)
                    state_next = iase_pkg::ST_PLACE;
            end
            iase_pkg::ST_PLACE:
                state_next = iase_pkg::ST_FIN;
            iase_pkg::ST_SCAN:
            begin
                if (scan_last || (cmd_reg == iase_pkg::CMD_SEARCH && key_hit))
                    state_next = iase_pkg::ST_FIN;
            end
            iase_pkg::ST_FIN:
            begin
                if (out_free)
                    state_next = iase_pkg::ST_IDLE;
            end
            default:
                state_next = iase_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath controls and next values
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        best_next       = best_reg;
        res_val_next    = res_val_reg;
        res_fidx_next   = res_fidx_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[iase_pkg::ADDR_BITS-1:0];
        mem_wdata       = val_reg;
        mem_raddr       = '0;

        unique case (state_reg)
            iase_pkg::ST_IDLE:
            begin
                // length load from the config port, saturating at DEPTH
                if (cfg_we)
                    count_next = (cfg_wdata > iase_pkg::CNT_BITS'(iase_pkg::DEPTH)) ?
                                 iase_pkg::CNT_BITS'(iase_pkg::DEPTH) : cfg_wdata;
                if (accept)
                begin
                    cmd_next        = iase_pkg::cmd_t'(cmd);
                    idx_next        = index;
                    val_next        = value;
                    res_val_next    = '0;
                    res_fidx_next   = '0;
                    res_found_next  = 1'b0;
                    res_status_next = iase_pkg::STATUS_OK;
                end
            end
            iase_pkg::ST_START:
            begin
                unique case (cmd_reg)
                    iase_pkg::CMD_GET:
                    begin
                        if (get_oor)
                            res_status_next = iase_pkg::STATUS_RANGE;
                        mem_raddr = idx_reg[iase_pkg::ADDR_BITS-1:0];
                    end
                    iase_pkg::CMD_SET:
                    begin
                        if (get_oor)
                            res_status_next = iase_pkg::STATUS_RANGE;
                        else
                            mem_we = 1'b1;
                    end
                    iase_pkg::CMD_INSERT:
                    begin
                        if (ins_oor)
                            res_status_next = iase_pkg::STATUS_RANGE;
                        else if (is_full)
                            res_status_next = iase_pkg::STATUS_FULL;
                        else if (ins_append)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        // shift starts from the top live entry
                        mem_raddr = iase_pkg::ADDR_BITS'(count_reg - 1'b1);
                    end
                    iase_pkg::CMD_MAX, iase_pkg::CMD_MIN:
                    begin
                        if (is_empty)
                            res_status_next = iase_pkg::STATUS_EMPTY;
                    end
                    default:
                    begin
                    end
                endcase
            end
            iase_pkg::ST_GET:
                res_val_next = eff_rd;
            iase_pkg::ST_SHIFT:
            begin
                // entry ptr moves up one place, next read is the one below
                mem_we    = 1'b1;
                mem_waddr = ptr_reg + 1'b1;
                mem_wdata = eff_rd;
                mem_raddr = ptr_reg - 1'b1;
            end
            iase_pkg::ST_PLACE:
            begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
            end
            iase_pkg::ST_SCAN:
            begin
                mem_raddr = ptr_reg + 1'b1;
                if (cmd_reg == iase_pkg::CMD_SEARCH)
                begin
                    if (key_hit)
                    begin
                        res_found_next = 1'b1;
                        res_fidx_next  = ptr_reg;
                    end
                end
                else
                begin
                    if (ptr_reg == '0 || better)
                        best_next = eff_rd;
                    if (scan_last)
                        res_val_next = best_next;
                end
            end
            iase_pkg::ST_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign ptr_next = mem_raddr;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iase_pkg::ST_IDLE;
            count_reg     <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_vld_reg <= vld_reg[mem_raddr];
            if (mem_we)
                vld_reg[mem_waddr] <= 1'b1;
            if (state_reg == iase_pkg::ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        ptr_reg        <= ptr_next;
        best_reg       <= best_next;
        res_val_reg    <= res_val_next;
        res_fidx_reg   <= res_fidx_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (state_reg == iase_pkg::ST_FIN && out_free)
        begin
            out_val_reg    <= res_val_reg;
            out_fidx_reg   <= res_fidx_reg;
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
            out_len_reg    <= count_reg;
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid   = out_valid_reg;
    assign read_value  = out_val_reg;
    assign found_index = out_fidx_reg;
    assign found       = out_found_reg;
    assign status      = out_status_reg;
    assign live_length = out_len_reg;

endmodule

[rtl/iase_checker.sv]
// Port-level checker for the indexed array store engine, bound to the top level.
`include "indexed_array_store_engine_defines.svh"

module iase_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic signed [31:0] read_value,
    input  logic [5:0]  found_index,
    input  logic        found,
    input  logic [1:0]  status,
    input  logic [6:0]  live_length
);

    `IASE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(read_value) && $stable(status) && $stable(live_length))

    `IASE_ASSERT_NOW(a_len_bound, out_valid,
        live_length <= 7'(iase_pkg::DEPTH))

    `IASE_ASSERT_NOW(a_found_ok, out_valid && found,
        status == iase_pkg::STATUS_OK)

    `IASE_ASSERT_NOW(a_err_clean, out_valid && status != iase_pkg::STATUS_OK,
        !found && found_index == '0 && read_value == '0)

    `IASE_ASSERT_NOW(a_full_len, out_valid && status == iase_pkg::STATUS_FULL,
        live_length == 7'(iase_pkg::DEPTH))

endmodule

bind indexed_array_store_engine iase_checker u_iase_checker (.*);
